### rtl/hcs_pkg.sv
// ----------------------------------------------------------------------------
// hcs_pkg
// Shared types, constants and helpers of the hit chain scorer.
// ----------------------------------------------------------------------------
package hcs_pkg;

    localparam int WINDOW_DEPTH_DEF = 256;

    localparam logic [30:0] CLUMP_COST_RST = 31'd50000;
    localparam logic [30:0] MAX_JUMP_RST   = 31'd200000;

    // configuration register indexes
    localparam logic [0:0] REG_CLUMP_COST = 1'b0;
    localparam logic [0:0] REG_MAX_JUMP   = 1'b1;

    localparam logic signed [34:0] S32_MAX = 35'sh0_7FFF_FFFF;
    localparam logic signed [34:0] S32_MIN = 35'sh7_8000_0000;

    // one stored hit of the window
    typedef struct packed {
        logic [31:0]        qry_iid;
        logic [30:0]        qry_end;
        logic [31:0]        ref_iid;
        logic [30:0]        ref_beg;
        logic [30:0]        ref_end;
        logic               forward;
        logic signed [31:0] best_score;
    } entry_t;

    // incoming hit
    typedef struct packed {
        logic [31:0] qry_iid;
        logic [30:0] qry_beg;
        logic [30:0] qry_end;
        logic [31:0] ref_iid;
        logic [30:0] ref_beg;
        logic [30:0] ref_end;
        logic        forward;
        logic        last_hit;
    } hit_t;

    // running result of the window scan
    typedef struct packed {
        logic               found;
        logic [30:0]        first_idx;
        logic signed [31:0] score;
        logic signed [31:0] link;
    } scan_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < S32_MIN)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

### rtl/hcs_cell.sv
// ----------------------------------------------------------------------------
// hcs_cell
// One window cell: holds a stored hit and passes it to its neighbor on shift.
// ----------------------------------------------------------------------------
module hcs_cell
(
    input  logic            clk,
    input  logic            shift_en,
    input  hcs_pkg::entry_t d,
    output hcs_pkg::entry_t q
);

    hcs_pkg::entry_t q_reg;

    // take the neighbor's entry on every shift
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            q_reg <= d;
        end
    end

    assign q = q_reg;

endmodule

### rtl/hcs_scan.sv
// ----------------------------------------------------------------------------
// hcs_scan
// Chaining test at the end of the cell row: finds the oldest reachable hit
// and the best extension as the window rotates past, oldest first.
// ----------------------------------------------------------------------------
module hcs_scan
(
    input  logic               clk,
    input  logic               start,
    input  logic               step,
    input  logic               in_range,
    input  logic [30:0]        idx_j,
    input  hcs_pkg::entry_t    ent,
    input  hcs_pkg::hit_t      hit,
    input  logic [30:0]        max_jump,
    input  logic [30:0]        clump_cost,
    input  logic signed [31:0] len,
    output hcs_pkg::scan_t     res
);

    hcs_pkg::scan_t     res_reg;
    hcs_pkg::scan_t     res_next;
    logic               reach_ok;
    logic               ref_ok;
    logic               chain_ok;
    logic               active;
    logic signed [31:0] cand;
    logic [31:0]        qend_far;
    logic [31:0]        rend_far;
    logic [31:0]        rbeg_far;

    // reach and chaining conditions of the entry under test
    always_comb
    begin
        qend_far = {1'b0, ent.qry_end} + {1'b0, max_jump};
        rend_far = {1'b0, ent.ref_end} + {1'b0, max_jump};
        rbeg_far = {1'b0, hit.ref_beg} + {1'b0, max_jump};
        reach_ok = (ent.qry_iid == hit.qry_iid) && (qend_far >= {1'b0, hit.qry_beg});
        if (ent.forward)
        begin
            ref_ok = ({1'b0, hit.ref_beg} <= rend_far) && (hit.ref_beg >= ent.ref_beg);
        end
        else
        begin
            ref_ok = ({1'b0, ent.ref_end} <= rbeg_far) && (hit.ref_beg <= ent.ref_beg);
        end
        chain_ok = reach_ok && ref_ok && (ent.ref_iid == hit.ref_iid)
                   && (ent.forward == hit.forward);
        active   = in_range && (res_reg.found || reach_ok);
        cand     = hcs_pkg::sat32(35'(ent.best_score) + 35'(len));
    end

    // clear at item start, fold one entry per step
    always_comb
    begin
        res_next = res_reg;
        if (start)
        begin
            res_next.found     = 1'b0;
            res_next.first_idx = '0;
            res_next.score     = -$signed({1'b0, clump_cost});
            res_next.link      = -32'sd1;
        end
        else if (step)
        begin
            if (in_range && !res_reg.found && reach_ok)
            begin
                res_next.found     = 1'b1;
                res_next.first_idx = idx_j;
            end
            if (active && chain_ok && (res_reg.score < cand))
            begin
                res_next.score = cand;
                res_next.link  = $signed({1'b0, idx_j});
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

### rtl/hit_chain_scorer.sv
// ----------------------------------------------------------------------------
// hit_chain_scorer
// Colinear chaining of sorted alignment hits with a window of recent hits.
// ----------------------------------------------------------------------------
// The window is a ring of WINDOW_DEPTH cells. Each item rotates the whole ring
// once past a single chaining test, oldest entry first, then shifts the new
// hit in. The result is loaded into the output register as the new hit is
// shifted in, and the next item is taken only once the block is idle again,
// so no new hit is accepted before the last one is through. The ring length
// sets the interval between items while the output is free; a result held by
// a stalled m_tready keeps the block from closing the next item until it is
// taken. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module hit_chain_scorer
#(
    parameter int WINDOW_DEPTH = hcs_pkg::WINDOW_DEPTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    // configuration
    input  logic         cfg_we,
    input  logic [0:0]   cfg_addr,
    input  logic [30:0]  cfg_wdata,
    // hits in
    input  logic         s_tvalid,
    output logic         s_tready,
    // qry_iid, qry_beg, qry_end, ref_iid, ref_beg, ref_end, 4 bits zero
    input  logic [191:0] s_tdata,
    // forward
    input  logic [0:0]   s_tuser,
    // last_hit
    input  logic         s_tlast,
    // results out
    output logic         m_tvalid,
    input  logic         m_tready,
    // hit_index, score_start, start_link, score_extend, extend_link, best_end,
    // 1 bit zero
    output logic [191:0] m_tdata,
    // window_overflow
    output logic [0:0]   m_tuser
);

    localparam int CNT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int AGE_W = $clog2(WINDOW_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(WINDOW_DEPTH - 1);
    localparam logic [AGE_W-1:0] DEPTH_AGE = AGE_W'(WINDOW_DEPTH);
    localparam logic [30:0]      DEPTH_IDX = 31'(WINDOW_DEPTH);

    hcs_pkg::state_t    state_reg;
    hcs_pkg::state_t    state_next;
    logic [CNT_W-1:0]   cnt_reg;
    hcs_pkg::hit_t      hit_reg;
    logic [AGE_W-1:0]   age_reg;
    logic               ovf_reg;
    logic [30:0]        clump_cost_reg;
    logic [30:0]        max_jump_reg;
    logic [30:0]        hit_count_reg;
    logic [30:0]        oldest_reach_reg;
    logic signed [31:0] prev_ube_reg;
    logic signed [31:0] ube_reg;
    logic signed [31:0] ubs_reg;
    logic [31:0]        prev_qiid_reg;
    logic               out_valid_reg;
    logic [191:0]       out_data_reg;
    logic               out_ovf_reg;

    logic               in_acc;
    logic               finish;
    logic               new_unit;
    logic [30:0]        age_diff;
    logic [AGE_W-1:0]   age_thresh;
    logic               in_range;
    logic [30:0]        idx_j;
    logic signed [31:0] len;
    logic signed [31:0] score_start;
    logic signed [31:0] start_link;
    logic signed [31:0] best;
    logic               best_up;
    logic signed [31:0] best_end;
    hcs_pkg::scan_t     scan_res;
    hcs_pkg::entry_t    new_entry;
    hcs_pkg::entry_t    cell0_d;
    hcs_pkg::entry_t    cell_q [WINDOW_DEPTH];
    logic               shift_en;

    assign s_tready = (state_reg == hcs_pkg::ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign finish   = (state_reg == hcs_pkg::ST_DONE) && (!out_valid_reg || m_tready);
    assign new_unit = (hit_count_reg == '0) || (s_tdata[31:0] != prev_qiid_reg);
    assign age_diff = hit_count_reg - oldest_reach_reg;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hcs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hcs_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = hcs_pkg::ST_SCAN;
                end
            end
            hcs_pkg::ST_SCAN:
            begin
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = hcs_pkg::ST_DONE;
                end
            end
            hcs_pkg::ST_DONE:
            begin
                if (finish)
                begin
                    state_next = hcs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hcs_pkg::ST_IDLE;
            end
        endcase
    end

    // start option and scan window bounds
    always_comb
    begin
        len        = $signed({1'b0, hit_reg.qry_end}) - $signed({1'b0, hit_reg.qry_beg});
        age_thresh = DEPTH_AGE - age_reg;
        in_range   = AGE_W'(cnt_reg) >= age_thresh;
        idx_j      = hit_count_reg - DEPTH_IDX + 31'(cnt_reg);
        if ((ube_reg >= 0) && (ubs_reg >= 0))
        begin
            score_start = hcs_pkg::sat32(35'(len) + 35'(ubs_reg)
                                         - $signed({4'b0, clump_cost_reg}));
            start_link  = ube_reg;
        end
        else
        begin
            score_start = hcs_pkg::sat32(35'(len) - $signed({4'b0, clump_cost_reg}));
            start_link  = prev_ube_reg;
        end
        best     = (score_start > scan_res.score) ? score_start : scan_res.score;
        best_up  = best > ubs_reg;
        best_end = best_up ? $signed({1'b0, hit_count_reg}) : ube_reg;
    end

    // new entry and ring feed
    always_comb
    begin
        new_entry.qry_iid    = hit_reg.qry_iid;
        new_entry.qry_end    = hit_reg.qry_end;
        new_entry.ref_iid    = hit_reg.ref_iid;
        new_entry.ref_beg    = hit_reg.ref_beg;
        new_entry.ref_end    = hit_reg.ref_end;
        new_entry.forward    = hit_reg.forward;
        new_entry.best_score = best;
        shift_en = (state_reg == hcs_pkg::ST_SCAN) || finish;
        cell0_d  = (state_reg == hcs_pkg::ST_SCAN) ? cell_q[WINDOW_DEPTH-1] : new_entry;
    end

    // row of window cells
    for (genvar k = 0; k < WINDOW_DEPTH; k++)
    begin : g_cell
        if (k == 0)
        begin : g_head
            hcs_cell u_cell
            (
                .clk      (clk),
                .shift_en (shift_en),
                .d        (cell0_d),
                .q        (cell_q[k])
            );
        end
        else
        begin : g_body
            hcs_cell u_cell
            (
                .clk      (clk),
                .shift_en (shift_en),
                .d        (cell_q[k-1]),
                .q        (cell_q[k])
            );
        end
    end

    hcs_scan u_scan
    (
        .clk        (clk),
        .start      (in_acc),
        .step       (state_reg == hcs_pkg::ST_SCAN),
        .in_range   (in_range),
        .idx_j      (idx_j),
        .ent        (cell_q[WINDOW_DEPTH-1]),
        .hit        (hit_reg),
        .max_jump   (max_jump_reg),
        .clump_cost (clump_cost_reg),
        .len        (len),
        .res        (scan_res)
    );

    // item payload, held for the scan
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            hit_reg.qry_iid  <= s_tdata[31:0];
            hit_reg.qry_beg  <= s_tdata[62:32];
            hit_reg.qry_end  <= s_tdata[93:63];
            hit_reg.ref_iid  <= s_tdata[125:94];
            hit_reg.ref_beg  <= s_tdata[156:126];
            hit_reg.ref_end  <= s_tdata[187:157];
            hit_reg.forward  <= s_tuser[0];
            hit_reg.last_hit <= s_tlast;
        end
        if (finish)
        begin
            out_data_reg <= {1'b0, best_end, scan_res.link, scan_res.score,
                             start_link, score_start, hit_count_reg};
            out_ovf_reg  <= ovf_reg;
        end
    end

    // control and chaining state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg          <= '0;
            age_reg          <= '0;
            ovf_reg          <= 1'b0;
            clump_cost_reg   <= hcs_pkg::CLUMP_COST_RST;
            max_jump_reg     <= hcs_pkg::MAX_JUMP_RST;
            hit_count_reg    <= '0;
            oldest_reach_reg <= '0;
            prev_ube_reg     <= -32'sd1;
            ube_reg          <= -32'sd1;
            ubs_reg          <= -$signed({1'b0, hcs_pkg::CLUMP_COST_RST});
            prev_qiid_reg    <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            // configuration writes
            if (cfg_we)
            begin
                case (cfg_addr)
                    hcs_pkg::REG_CLUMP_COST: clump_cost_reg <= cfg_wdata;
                    hcs_pkg::REG_MAX_JUMP:   max_jump_reg   <= cfg_wdata;
                    default:                 ;
                endcase
            end

            // accept: size the scan and open a new query unit when a new query starts
            if (in_acc)
            begin
                cnt_reg <= '0;
                if (age_diff > DEPTH_IDX)
                begin
                    ovf_reg <= 1'b1;
                    age_reg <= DEPTH_AGE;
                end
                else
                begin
                    ovf_reg <= 1'b0;
                    age_reg <= age_diff[AGE_W-1:0];
                end
                if (new_unit)
                begin
                    prev_ube_reg <= ube_reg;
                    ube_reg      <= $signed({1'b0, hit_count_reg}) - 32'sd1;
                    ubs_reg      <= -$signed({1'b0, clump_cost_reg});
                end
            end

            // advance the scan counter
            if (state_reg == hcs_pkg::ST_SCAN)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end

            // close the item
            if (finish)
            begin
                if (hit_reg.last_hit)
                begin
                    hit_count_reg    <= '0;
                    oldest_reach_reg <= '0;
                    prev_ube_reg     <= -32'sd1;
                    ube_reg          <= -32'sd1;
                    ubs_reg          <= -$signed({1'b0, clump_cost_reg});
                    prev_qiid_reg    <= '0;
                end
                else
                begin
                    hit_count_reg    <= hit_count_reg + 31'd1;
                    oldest_reach_reg <= scan_res.found ? scan_res.first_idx : hit_count_reg;
                    prev_qiid_reg    <= hit_reg.qry_iid;
                    if (best_up)
                    begin
                        ubs_reg <= best;
                        ube_reg <= best_end;
                    end
                end
            end

            // output register
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_ovf_reg;

endmodule

### rtl/hcs_checker.sv
// ----------------------------------------------------------------------------
// hcs_checker
// Port-level checks of the hit chain scorer, bound to the top level.
// ----------------------------------------------------------------------------
module hcs_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [191:0] m_tdata
);

    // one item at a time: input closes right after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input stayed open after accept");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // links never below none
    a_links: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[94:63]) >= -32'sd1)
                  && ($signed(m_tdata[158:127]) >= -32'sd1))
        else $error("link below -1");

    // best end never below none
    a_best_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $signed(m_tdata[190:159]) >= -32'sd1)
        else $error("best end below -1");

endmodule

bind hit_chain_scorer hcs_checker u_hcs_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
